// ----- hw/rtl/uqe_pkg.sv -----
package uqe_pkg;

   localparam logic [2:0] REQ_RX_BYTE    = 3'd0;
   localparam logic [2:0] REQ_LINE_IDLE  = 3'd1;
   localparam logic [2:0] REQ_HOST_READ  = 3'd2;
   localparam logic [2:0] REQ_HOST_WRITE = 3'd3;
   localparam logic [2:0] REQ_TX_PULL    = 3'd4;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] data;
   } req_item_type;

   typedef struct packed {
      logic       accepted;
      logic       read_valid;
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_data;
      logic       tx_last;
      logic       batch_started;
      logic [6:0] batch_len;
      logic [8:0] ready_count;
      logic [8:0] tx_pending;
   } rsp_item_type;

endpackage

// ----- hw/rtl/uqe_stream_if.sv -----
interface uqe_stream_if #(
   parameter type item_type = logic
);
   logic     valid;
   logic     ready;
   item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/uqe_ram.sv -----
module uqe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/uart_rx_tx_byte_queue_engine_core.sv -----
// Channel   Direction  Payload                  Handshake
// req_chan  in         req_type, data           valid/ready
// rsp_chan  out        ten status/data fields   valid/ready
//
// Each transaction yields one response. Receive byte and line idle go straight
// to the response state; a host read or transmitter pull with a byte to return
// first passes a read state (one registered memory read). A write or last pull
// that starts a batch copies its n bytes, one byte a cycle, into the batch memory.
// Reset is synchronous; the stores need no clearing pass. A stalled response
// is held in the output register while the next request can already be taken.
module uart_rx_tx_byte_queue_engine_core #(
   parameter int QUEUE_DEPTH = 256,
   parameter int BATCH_MAX   = 64
) (
   input  logic          clock,
   input  logic          reset,
   uqe_stream_if.sink    req_chan,
   uqe_stream_if.source  rsp_chan
);
   localparam int AW  = $clog2(QUEUE_DEPTH);
   localparam int FW  = $clog2(QUEUE_DEPTH + 1);
   localparam int BAW = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
   localparam int PW  = $clog2(BATCH_MAX + 1);
   localparam int CW  = (FW > PW) ? FW : PW;

   localparam logic [FW-1:0] DEPTH_F = FW'(QUEUE_DEPTH);
   localparam logic [AW-1:0] LAST_A  = AW'(QUEUE_DEPTH - 1);
   localparam logic [PW-1:0] BATCH_F = PW'(BATCH_MAX);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RXRD = 3'd1;
   localparam logic [2:0] ST_TXRD = 3'd2;
   localparam logic [2:0] ST_LOAD = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] rx_head_ff, rx_head_in;
   logic [FW-1:0] rx_fill_ff, rx_fill_in;
   logic [FW-1:0] rx_ready_ff, rx_ready_in;
   logic [AW-1:0] tx_head_ff, tx_head_in;
   logic [FW-1:0] tx_fill_ff, tx_fill_in;
   logic [PW-1:0] batch_size_ff, batch_size_in;
   logic [PW-1:0] batch_pos_ff, batch_pos_in;
   logic          tx_busy_ff, tx_busy_in;
   logic [PW-1:0] ld_cnt_ff, ld_cnt_in;
   logic          ld_wr_ff, ld_wr_in;
   logic [BAW-1:0] ld_idx_ff, ld_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   uqe_pkg::rsp_item_type res_ff, res_in;
   uqe_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   logic          rx_we, rx_re;
   logic [AW-1:0] rx_waddr;
   logic [7:0]    rx_rdata;
   logic          tx_we, tx_re;
   logic [AW-1:0] tx_waddr;
   logic [7:0]    tx_rdata;
   logic          bt_re;
   logic [7:0]    bt_rdata;

   logic [FW:0]   rx_sum, tx_sum;
   logic [FW-1:0] tx_fill_inc;
   logic [PW-1:0] ld_n_write, ld_n_pull;
   logic [PW-1:0] pos_inc;

   function automatic logic [PW-1:0] clip_batch(input logic [FW-1:0] fill);
      logic [PW-1:0] n;
      if (CW'(fill) > CW'(BATCH_MAX)) begin
         n = BATCH_F;
      end else begin
         n = PW'(fill);
      end
      return n;
   endfunction

   function automatic logic [AW-1:0] wrap_addr(input logic [FW:0] sum);
      logic [FW:0] s;
      s = sum;
      if (s >= (FW + 1)'(QUEUE_DEPTH)) begin
         s = s - (FW + 1)'(QUEUE_DEPTH);
      end
      return AW'(s);
   endfunction

   assign rx_sum      = (FW + 1)'(rx_head_ff) + (FW + 1)'(rx_fill_ff);
   assign tx_sum      = (FW + 1)'(tx_head_ff) + (FW + 1)'(tx_fill_ff);
   assign rx_waddr    = wrap_addr(rx_sum);
   assign tx_waddr    = wrap_addr(tx_sum);
   assign tx_fill_inc = tx_fill_ff + FW'(1);
   assign ld_n_write  = clip_batch(tx_fill_inc);
   assign ld_n_pull   = clip_batch(tx_fill_ff);
   assign pos_inc     = batch_pos_ff + PW'(1);

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   uqe_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_we),
      .wr_addr (rx_waddr),
      .wr_data (req_chan.payload.data),
      .rd_en   (rx_re),
      .rd_addr (rx_head_ff),
      .rd_data (rx_rdata)
   );

   uqe_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_we),
      .wr_addr (tx_waddr),
      .wr_data (req_chan.payload.data),
      .rd_en   (tx_re),
      .rd_addr (tx_head_ff),
      .rd_data (tx_rdata)
   );

   uqe_ram #(.WIDTH(8), .DEPTH(BATCH_MAX)) u_batch_ram (
      .clock   (clock),
      .wr_en   (ld_wr_ff),
      .wr_addr (ld_idx_ff),
      .wr_data (tx_rdata),
      .rd_en   (bt_re),
      .rd_addr (batch_pos_ff[BAW-1:0]),
      .rd_data (bt_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      rx_head_in    = rx_head_ff;
      rx_fill_in    = rx_fill_ff;
      rx_ready_in   = rx_ready_ff;
      tx_head_in    = tx_head_ff;
      tx_fill_in    = tx_fill_ff;
      batch_size_in = batch_size_ff;
      batch_pos_in  = batch_pos_ff;
      tx_busy_in    = tx_busy_ff;
      ld_cnt_in     = ld_cnt_ff;
      ld_wr_in      = 1'b0;
      ld_idx_in     = ld_idx_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rx_we         = 1'b0;
      rx_re         = 1'b0;
      tx_we         = 1'b0;
      tx_re         = 1'b0;
      bt_re         = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               res_in   = '0;
               state_in = ST_DONE;
               case (req_chan.payload.req_type)
                  uqe_pkg::REQ_RX_BYTE: begin
                     if (rx_fill_ff < DEPTH_F) begin
                        rx_we           = 1'b1;
                        rx_fill_in      = rx_fill_ff + FW'(1);
                        res_in.accepted = 1'b1;
                     end
                  end
                  uqe_pkg::REQ_LINE_IDLE: begin
                     rx_ready_in = rx_fill_ff;
                  end
                  uqe_pkg::REQ_HOST_READ: begin
                     if (rx_ready_ff != '0) begin
                        rx_ready_in = rx_ready_ff - FW'(1);
                        if (rx_fill_ff != '0) begin
                           rx_re    = 1'b1;
                           state_in = ST_RXRD;
                        end
                     end
                  end
                  uqe_pkg::REQ_HOST_WRITE: begin
                     if (tx_fill_ff < DEPTH_F) begin
                        tx_we           = 1'b1;
                        tx_fill_in      = tx_fill_inc;
                        res_in.accepted = 1'b1;
                        if (!tx_busy_ff) begin
                           tx_fill_in           = tx_fill_inc - FW'(ld_n_write);
                           batch_size_in        = ld_n_write;
                           batch_pos_in         = '0;
                           tx_busy_in           = 1'b1;
                           ld_cnt_in            = '0;
                           res_in.batch_started = 1'b1;
                           res_in.batch_len     = 7'(ld_n_write);
                           state_in             = ST_LOAD;
                        end
                     end
                  end
                  uqe_pkg::REQ_TX_PULL: begin
                     if (tx_busy_ff && (batch_pos_ff < batch_size_ff)
                           && (batch_pos_ff < BATCH_F)) begin
                        bt_re    = 1'b1;
                        state_in = ST_TXRD;
                     end else if (tx_busy_ff) begin
                        tx_busy_in = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RXRD: begin
            res_in.read_valid = 1'b1;
            res_in.read_data  = rx_rdata;
            rx_head_in        = (rx_head_ff == LAST_A) ? '0 : rx_head_ff + AW'(1);
            rx_fill_in        = rx_fill_ff - FW'(1);
            state_in          = ST_DONE;
         end
         ST_TXRD: begin
            res_in.tx_valid = 1'b1;
            res_in.tx_data  = bt_rdata;
            batch_pos_in    = pos_inc;
            state_in        = ST_DONE;
            if (pos_inc >= batch_size_ff) begin
               res_in.tx_last = 1'b1;
               tx_busy_in     = 1'b0;
               if (tx_fill_ff != '0) begin
                  tx_fill_in           = tx_fill_ff - FW'(ld_n_pull);
                  batch_size_in        = ld_n_pull;
                  batch_pos_in         = '0;
                  tx_busy_in           = 1'b1;
                  ld_cnt_in            = '0;
                  res_in.batch_started = 1'b1;
                  res_in.batch_len     = 7'(ld_n_pull);
                  state_in             = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            if (ld_cnt_ff < batch_size_ff) begin
               tx_re      = 1'b1;
               tx_head_in = (tx_head_ff == LAST_A) ? '0 : tx_head_ff + AW'(1);
               ld_cnt_in  = ld_cnt_ff + PW'(1);
               ld_wr_in   = 1'b1;
               ld_idx_in  = ld_cnt_ff[BAW-1:0];
            end else if (!ld_wr_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = res_ff;
               rsp_data_in.ready_count = 9'(rx_ready_ff);
               rsp_data_in.tx_pending  = 9'(tx_fill_ff);
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rx_head_ff    <= '0;
         rx_fill_ff    <= '0;
         rx_ready_ff   <= '0;
         tx_head_ff    <= '0;
         tx_fill_ff    <= '0;
         batch_size_ff <= '0;
         batch_pos_ff  <= '0;
         tx_busy_ff    <= 1'b0;
         ld_cnt_ff     <= '0;
         ld_wr_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rx_head_ff    <= rx_head_in;
         rx_fill_ff    <= rx_fill_in;
         rx_ready_ff   <= rx_ready_in;
         tx_head_ff    <= tx_head_in;
         tx_fill_ff    <= tx_fill_in;
         batch_size_ff <= batch_size_in;
         batch_pos_ff  <= batch_pos_in;
         tx_busy_ff    <= tx_busy_in;
         ld_cnt_ff     <= ld_cnt_in;
         ld_wr_ff      <= ld_wr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ld_idx_ff   <= ld_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule

// ----- hw/rtl/uqe_checker.sv -----
module uqe_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input uqe_pkg::rsp_item_type rsp_payload
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Response changed while stalled.");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.read_valid |-> rsp_payload.read_data == 8'd0)
      else $error("Read data is not zero without a valid read.");

   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.tx_last |-> rsp_payload.tx_valid)
      else $error("Batch end flagged without a pulled byte.");

   a_batch_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.batch_started == (rsp_payload.batch_len != 7'd0))
      else $error("Batch start and batch length disagree.");

   a_batch_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.batch_started
         |-> rsp_payload.accepted || rsp_payload.tx_last)
      else $error("Batch started without a write or a batch end.");
endmodule

bind uart_rx_tx_byte_queue_engine_core uqe_checker u_uqe_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
